// ===== sv/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/mvm_pkg.sv =====
`timescale 1ns / 1ps
package mvm_pkg;

  localparam int MAX_DIM     = 64;
  localparam int IDX_W       = $clog2(MAX_DIM);
  localparam int CNT_W       = IDX_W + 1;
  localparam int DATA_W      = 16;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int SUM_W       = 48;
  localparam int REG_IDX_W   = 2;
  localparam int CFG_W       = CNT_W;
  localparam int IN_FIELDS_W = IDX_W + DATA_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = SUM_W + IDX_W;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_MATRIX = 1'b1
  } op_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROW_COUNT    = 2'd0,
    REG_COLUMN_COUNT = 2'd1,
    REG_TRANSPOSE    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             row_end;
    logic             col_end;
    logic             first_col;
  } elem_ctl_t;

  typedef struct packed {
    logic                    valid;
    logic signed [SUM_W-1:0] value;
    logic [IDX_W-1:0]        index;
    logic                    last;
  } result_t;

endpackage

// ===== sv/mvm_accum.sv =====
`timescale 1ns / 1ps
module mvm_accum import mvm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     clear,
  input  logic                     transpose,
  input  logic                     s1_valid,
  input  elem_ctl_t                s1_ctl,
  input  logic signed [DATA_W-1:0] s1_a,
  input  logic signed [DATA_W-1:0] vec_rd,
  output result_t                  res
);

  logic                     s2_valid;
  elem_ctl_t                s2_ctl;
  logic signed [PROD_W-1:0] product;
  logic signed [SUM_W-1:0]  psum_rd;
  logic signed [SUM_W-1:0]  dot_acc;
  logic signed [SUM_W-1:0]  dot_acc_next;
  logic signed [SUM_W-1:0]  prod_ext;
  logic signed [SUM_W-1:0]  sum;
  logic                     fwd;
  logic                     psum_we;

  logic signed [SUM_W-1:0] psum_mem [MAX_DIM];

  assign prod_ext     = SUM_W'(product);
  assign sum          = s2_ctl.first_col ? prod_ext : psum_rd + prod_ext;
  assign dot_acc_next = dot_acc + prod_ext;
  assign psum_we      = en && s2_valid && !transpose;
  // row sum written back this edge while the next element of that row reads it
  assign fwd          = psum_we && (s2_ctl.row == s1_ctl.row);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ctl  <= s1_ctl;
      product <= s1_a * vec_rd;
      psum_rd <= fwd ? sum : psum_mem[s1_ctl.row];
    end
  end

  always_ff @(posedge clk) begin
    if (psum_we) begin
      psum_mem[s2_ctl.row] <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      dot_acc <= '0;
    end else if (en && s2_valid && transpose) begin
      dot_acc <= s2_ctl.row_end ? '0 : dot_acc_next;
    end
  end

  always_comb begin
    res.valid = s2_valid && (transpose ? s2_ctl.row_end : s2_ctl.col_end);
    res.value = transpose ? dot_acc_next : sum;
    res.index = transpose ? s2_ctl.col : s2_ctl.row;
    res.last  = s2_ctl.row_end && s2_ctl.col_end;
  end

endmodule

// ===== sv/matrix_vector_multiply.sv =====
`timescale 1ns / 1ps
// a result passes the s1 registers, the s2 registers and the output register after acceptance
// throughput: one request per cycle unless output stalls, set by vector read and mac pipeline
// a full output register that is not taken holds the whole pipeline and input
// reset: counts return to 1, transpose off, positions and dot accumulator to zero
// reset leaves the vector and partial sum memories as they are
module matrix_vector_multiply import mvm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // vector_index, in_value
  input  logic                   s_axis_tuser,   // operation
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // out_value, out_index
  output logic                   m_axis_tlast,   // last
  input  logic                   cfg_write,
  input  logic [REG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  logic [CNT_W-1:0] row_count;
  logic [CNT_W-1:0] column_count;
  logic             transpose;
  logic [CNT_W-1:0] m_eff;
  logic [CNT_W-1:0] n_eff;
  logic [IDX_W-1:0] row_pos;
  logic [IDX_W-1:0] col_pos;
  logic             row_end;
  logic             col_end;
  logic             en;
  logic             accept;
  logic             is_matrix;
  logic             cfg_restart;
  logic [IDX_W-1:0] in_index;
  logic signed [DATA_W-1:0] in_value;
  logic [IDX_W-1:0] vec_addr;

  logic                     s1_valid;
  elem_ctl_t                s1_ctl;
  logic signed [DATA_W-1:0] s1_a;
  logic signed [DATA_W-1:0] vec_rd;
  result_t                  res;

  logic signed [DATA_W-1:0] vector_store [MAX_DIM];

  assign in_index  = s_axis_tdata[IDX_W-1:0];
  assign in_value  = s_axis_tdata[IN_FIELDS_W-1:IDX_W];
  assign en        = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign is_matrix = (op_t'(s_axis_tuser) == OP_MATRIX);

  // only writes to a known register restart the stream
  assign cfg_restart = cfg_write && (reg_idx_t'(cfg_index) == REG_ROW_COUNT ||
                                     reg_idx_t'(cfg_index) == REG_COLUMN_COUNT ||
                                     reg_idx_t'(cfg_index) == REG_TRANSPOSE);

  always_comb begin
    if (row_count == '0) begin
      m_eff = CNT_W'(1);
    end else if (row_count > CNT_W'(MAX_DIM)) begin
      m_eff = CNT_W'(MAX_DIM);
    end else begin
      m_eff = row_count;
    end
    if (column_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (column_count > CNT_W'(MAX_DIM)) begin
      n_eff = CNT_W'(MAX_DIM);
    end else begin
      n_eff = column_count;
    end
  end

  assign row_end  = ({1'b0, row_pos} + CNT_W'(1)) >= m_eff;
  assign col_end  = ({1'b0, col_pos} + CNT_W'(1)) >= n_eff;
  assign vec_addr = transpose ? row_pos : col_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= CNT_W'(1);
      column_count <= CNT_W'(1);
      transpose    <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ROW_COUNT:    row_count    <= cfg_data;
        REG_COLUMN_COUNT: column_count <= cfg_data;
        REG_TRANSPOSE:    transpose    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (accept && is_matrix) begin
      if (row_end) begin
        row_pos <= '0;
        col_pos <= col_end ? '0 : col_pos + IDX_W'(1);
      end else begin
        row_pos <= row_pos + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_matrix) begin
      vector_store[in_index] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_rd <= vector_store[vec_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept && is_matrix;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ctl.row       <= row_pos;
      s1_ctl.col       <= col_pos;
      s1_ctl.row_end   <= row_end;
      s1_ctl.col_end   <= col_end;
      s1_ctl.first_col <= (col_pos == '0);
      s1_a             <= in_value;
    end
  end

  mvm_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .clear     (cfg_restart),
    .transpose (transpose),
    .s1_valid  (s1_valid),
    .s1_ctl    (s1_ctl),
    .s1_a      (s1_a),
    .vec_rd    (vec_rd),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && res.valid) begin
      m_axis_tdata <= OUT_TDATA_W'({res.index, res.value});
      m_axis_tlast <= res.last;
    end
  end

endmodule

// ===== sv/mvm_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mvm_checker import mvm_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  logic                 out_stall;
  logic [OUT_TDATA_W:0] out_word;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tlast, m_axis_tdata};

  // a stalled result stays offered
  `ASSERT_CLK(a_out_hold, clk, rst, out_stall |=> m_axis_tvalid, "result dropped while stalled")

  // a stalled result keeps its payload
  `ASSERT_CLK(a_out_stable, clk, rst, out_stall |=> $stable(out_word), "result changed in stall")

  // reset empties the output register
  `ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_axis_tvalid, "result offered after reset")

  // input side is held off only while a result waits
  `ASSERT_CLK(a_ready_link, clk, rst, !s_axis_tready |-> out_stall, "input stalled, output free")

endmodule

bind matrix_vector_multiply mvm_checker u_mvm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import mvm_pkg::*;

  localparam int IDLE_PCT = 12;
  localparam int ITEM_TARGET = 1100;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT = 20000;
  localparam int HOLD_CYCLES = 200;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [SUM_W-1:0] value;
    logic [IDX_W-1:0]        index;
    logic                    last;
  } gemv_out_t;

  localparam gemv_out_t NO_RESULT = '0;

  typedef enum logic [1:0] {
    ROW_REG,
    ROW_REQ,
    ROW_REQ_NONE,
    ROW_REQ_WANT
  } row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [REG_IDX_W-1:0]    sel;
    op_t                     op;
    logic [IDX_W-1:0]        idx;
    logic [DATA_W-1:0]       data;
    logic signed [SUM_W-1:0] want_value;
    logic [IDX_W-1:0]        want_index;
    logic                    want_last;
  } stim_row_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata;   // vector_index, in_value
  logic s_axis_tuser;                    // operation
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;  // out_value, out_index
  logic m_axis_tlast;                    // last
  logic cfg_write;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  // predictor state
  logic signed [DATA_W-1:0] vec_mem [MAX_DIM];
  logic signed [SUM_W-1:0] row_sums [MAX_DIM];
  logic signed [SUM_W-1:0] dot_sum;
  logic [IDX_W-1:0] row_pos;
  logic [IDX_W-1:0] col_pos;
  logic [CNT_W-1:0] rows_reg;
  logic [CNT_W-1:0] cols_reg;
  logic tr_reg;
  bit loaded [MAX_DIM];

  gemv_out_t pending_sums [$];
  stim_row_t directed_rows [$];
  int fail_count;
  int checked_count;
  int req_count;
  int elem_count;
  int setting_count;
  int hold_len;
  bit steady;

  matrix_vector_multiply i_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int dim_of(input logic [CNT_W-1:0] c);
    if (c == 0) return 1;
    if (c > MAX_DIM) return MAX_DIM;
    return c;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic restart_stream();
    row_pos = '0;
    col_pos = '0;
    dot_sum = '0;
  endtask

  task automatic gemv_step(input op_t op, input logic [IDX_W-1:0] idx,
                           input logic signed [DATA_W-1:0] a,
                           output bit emit, output gemv_out_t res);
    int m;
    int n;
    bit row_end;
    bit col_end;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0] sum;
    emit = 1'b0;
    res = NO_RESULT;
    if (op == OP_LOAD) begin
      vec_mem[idx] = a;
      loaded[idx] = 1'b1;
      return;
    end
    m = dim_of(rows_reg);
    n = dim_of(cols_reg);
    row_end = (int'(row_pos) + 1 >= m);
    col_end = (int'(col_pos) + 1 >= n);
    if (tr_reg) begin
      prod = a * vec_mem[row_pos];
      dot_sum = dot_sum + prod;
      if (row_end) begin
        emit = 1'b1;
        res.value = dot_sum;
        res.index = col_pos;
        dot_sum = '0;
      end
    end else begin
      prod = a * vec_mem[col_pos];
      if (col_pos == 0) sum = prod;
      else sum = row_sums[row_pos] + prod;
      row_sums[row_pos] = sum;
      if (col_end) begin
        emit = 1'b1;
        res.value = sum;
        res.index = row_pos;
      end
    end
    res.last = row_end && col_end;
    if (row_end) begin
      row_pos = '0;
      col_pos = col_end ? '0 : col_pos + 1'b1;
    end else begin
      row_pos = row_pos + 1'b1;
    end
  endtask

  task automatic offer_request(input op_t op, input logic [IDX_W-1:0] idx,
                               input logic [DATA_W-1:0] data, input bit typed,
                               input bit typed_emit, input gemv_out_t typed_res);
    bit emit;
    gemv_out_t res;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, data, idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    gemv_step(op, idx, data, emit, res);
    if (typed) begin
      emit = typed_emit;
      res = typed_res;
    end
    if (emit) pending_sums.push_back(res);
    req_count++;
    if (op == OP_MATRIX) elem_count++;
  endtask

  task automatic wait_results_done();
    int wait_cnt;
    s_axis_tvalid <= 1'b0;
    for (wait_cnt = 0; pending_sums.size() != 0 && wait_cnt < DRAIN_LIMIT; wait_cnt++)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] sel, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (sel)
      REG_ROW_COUNT: begin
        rows_reg = data;
        restart_stream();
      end
      REG_COLUMN_COUNT: begin
        cols_reg = data;
        restart_stream();
      end
      REG_TRANSPOSE: begin
        tr_reg = data[0];
        restart_stream();
      end
      default: ;
    endcase
    setting_count++;
    @(posedge clk);
  endtask

  // output side: random stalls plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : result_check
    gemv_out_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_sums.size() == 0) begin
        $error("unexpected result: out_value %0d out_index %0d",
               $signed(m_axis_tdata[SUM_W-1:0]), m_axis_tdata[SUM_W +: IDX_W]);
        fail_count++;
      end else begin
        want = pending_sums.pop_front();
        checked_count++;
        if ($signed(m_axis_tdata[SUM_W-1:0]) !== want.value) begin
          $error("out_value expected %0d actual %0d", want.value,
                 $signed(m_axis_tdata[SUM_W-1:0]));
          fail_count++;
        end
        if (m_axis_tdata[SUM_W +: IDX_W] !== want.index) begin
          $error("out_index expected %0d actual %0d", want.index,
                 m_axis_tdata[SUM_W +: IDX_W]);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last expected %0d actual %0d", want.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("matrix_vector_multiply test failed");
    $finish;
  end

  initial begin
    stim_row_t row;
    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] cols;
    logic tr;
    int m;
    int n;
    int reach;
    int mats;
    int total;
    int k;
    int phase_no;
    int wait_cnt;

    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fail_count = 0;
    checked_count = 0;
    req_count = 0;
    elem_count = 0;
    setting_count = 0;
    hold_len = 0;
    steady = 1'b0;
    rows_reg = 1;
    cols_reg = 1;
    tr_reg = 1'b0;
    restart_stream();

    // after reset: one row, one column, normal mode
    directed_rows.push_back('{ROW_REQ_NONE, REG_ROW_COUNT, OP_LOAD, 6'd0, 16'h7fff,
                              48'sd0, 6'd0, 1'b0});
    directed_rows.push_back('{ROW_REQ_WANT, REG_ROW_COUNT, OP_MATRIX, 6'd0, 16'h7fff,
                              48'sd1073676289, 6'd0, 1'b1});
    directed_rows.push_back('{ROW_REQ_NONE, REG_ROW_COUNT, OP_LOAD, 6'd0, 16'h8000,
                              48'sd0, 6'd0, 1'b0});
    directed_rows.push_back('{ROW_REQ_WANT, REG_ROW_COUNT, OP_MATRIX, 6'd63, 16'h8000,
                              48'sd1073741824, 6'd0, 1'b1});
    directed_rows.push_back('{ROW_REQ_WANT, REG_ROW_COUNT, OP_MATRIX, 6'd0, 16'h7fff,
                              -48'sd1073709056, 6'd0, 1'b1});
    directed_rows.push_back('{ROW_REQ_WANT, REG_ROW_COUNT, OP_MATRIX, 6'd21, 16'h0000,
                              48'sd0, 6'd0, 1'b1});
    directed_rows.push_back('{ROW_REQ_NONE, REG_ROW_COUNT, OP_LOAD, 6'd63, 16'h8000,
                              48'sd0, 6'd0, 1'b0});
    directed_rows.push_back('{ROW_REQ_NONE, REG_ROW_COUNT, OP_LOAD, 6'd1, 16'h0001,
                              48'sd0, 6'd0, 1'b0});
    directed_rows.push_back('{ROW_REQ_NONE, REG_ROW_COUNT, OP_LOAD, 6'd2, 16'hffff,
                              48'sd0, 6'd0, 1'b0});
    // zero row count acts as one
    directed_rows.push_back('{ROW_REG, REG_ROW_COUNT, OP_LOAD, 6'd0, 16'd0,
                              48'sd0, 6'd0, 1'b0});
    directed_rows.push_back('{ROW_REG, REG_COLUMN_COUNT, OP_LOAD, 6'd0, 16'd3,
                              48'sd0, 6'd0, 1'b0});
    directed_rows.push_back('{ROW_REQ, REG_ROW_COUNT, OP_MATRIX, 6'd5, 16'h7fff,
                              48'sd0, 6'd0, 1'b0});
    directed_rows.push_back('{ROW_REQ, REG_ROW_COUNT, OP_MATRIX, 6'd0, 16'h8000,
                              48'sd0, 6'd0, 1'b0});
    directed_rows.push_back('{ROW_REQ, REG_ROW_COUNT, OP_MATRIX, 6'd0, 16'h1234,
                              48'sd0, 6'd0, 1'b0});
    // transpose, zero column count acts as one
    directed_rows.push_back('{ROW_REG, REG_TRANSPOSE, OP_LOAD, 6'd0, 16'd1,
                              48'sd0, 6'd0, 1'b0});
    directed_rows.push_back('{ROW_REG, REG_ROW_COUNT, OP_LOAD, 6'd0, 16'd3,
                              48'sd0, 6'd0, 1'b0});
    directed_rows.push_back('{ROW_REG, REG_COLUMN_COUNT, OP_LOAD, 6'd0, 16'd0,
                              48'sd0, 6'd0, 1'b0});
    directed_rows.push_back('{ROW_REQ, REG_ROW_COUNT, OP_MATRIX, 6'd0, 16'hffff,
                              48'sd0, 6'd0, 1'b0});
    directed_rows.push_back('{ROW_REQ, REG_ROW_COUNT, OP_MATRIX, 6'd0, 16'h8000,
                              48'sd0, 6'd0, 1'b0});
    directed_rows.push_back('{ROW_REQ, REG_ROW_COUNT, OP_MATRIX, 6'd0, 16'h7fff,
                              48'sd0, 6'd0, 1'b0});
    // unused register index leaves everything alone
    directed_rows.push_back('{ROW_REG, REG_UNUSED, OP_LOAD, 6'd0, 16'h0055,
                              48'sd0, 6'd0, 1'b0});
    // partial matrix cut short by a register write
    directed_rows.push_back('{ROW_REG, REG_ROW_COUNT, OP_LOAD, 6'd0, 16'd2,
                              48'sd0, 6'd0, 1'b0});
    directed_rows.push_back('{ROW_REG, REG_COLUMN_COUNT, OP_LOAD, 6'd0, 16'd2,
                              48'sd0, 6'd0, 1'b0});
    directed_rows.push_back('{ROW_REQ, REG_ROW_COUNT, OP_MATRIX, 6'd0, 16'h4000,
                              48'sd0, 6'd0, 1'b0});
    directed_rows.push_back('{ROW_REG, REG_TRANSPOSE, OP_LOAD, 6'd0, 16'd0,
                              48'sd0, 6'd0, 1'b0});
    for (k = 0; k < 4; k++)
      directed_rows.push_back('{ROW_REQ, REG_ROW_COUNT, OP_MATRIX, 6'(k), 16'(k * 9001 - 7),
                                48'sd0, 6'd0, 1'b0});

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.kind)
        ROW_REG: begin
          wait_results_done();
          write_reg(row.sel, row.data[CFG_W-1:0]);
        end
        ROW_REQ_NONE: offer_request(row.op, row.idx, row.data, 1'b1, 1'b0, NO_RESULT);
        ROW_REQ_WANT: offer_request(row.op, row.idx, row.data, 1'b1, 1'b1,
                                    '{row.want_value, row.want_index, row.want_last});
        default: offer_request(row.op, row.idx, row.data, 1'b0, 1'b0, NO_RESULT);
      endcase
    end

    phase_no = 0;
    while (req_count < ITEM_TARGET) begin
      case (phase_no)
        0: begin rows = 64; cols = 2; tr = 1'b0; end
        1: begin rows = 2; cols = 127; tr = 1'b1; end
        2: begin rows = 127; cols = 1; tr = 1'b0; end
        3: begin rows = 1; cols = 64; tr = 1'b0; end
        4: begin rows = 0; cols = 0; tr = 1'b1; end
        5: begin rows = 1; cols = 6; tr = 1'b1; end
        default: begin
          rows = CNT_W'($urandom_range(1, 8));
          cols = CNT_W'($urandom_range(1, 8));
          tr = 1'($urandom_range(0, 1));
          if ($urandom_range(9) == 0) rows = 0;
          if ($urandom_range(9) == 0) cols = 0;
        end
      endcase
      wait_results_done();
      steady = (phase_no >= 8 && phase_no < 12);
      write_reg(REG_ROW_COUNT, rows);
      write_reg(REG_COLUMN_COUNT, cols);
      write_reg(REG_TRANSPOSE, CFG_W'(tr));
      if (phase_no == 4) write_reg(REG_UNUSED, CFG_W'($urandom));

      m = dim_of(rows);
      n = dim_of(cols);
      reach = tr ? m : n;
      for (k = 0; k < reach; k++)
        if (!loaded[k]) offer_request(OP_LOAD, IDX_W'(k), pick_value(), 1'b0, 1'b0, NO_RESULT);
      repeat ($urandom_range(0, 3))
        offer_request(OP_LOAD, IDX_W'($urandom_range(0, MAX_DIM - 1)), pick_value(),
                      1'b0, 1'b0, NO_RESULT);

      mats = (m * n > 32) ? 1 : $urandom_range(1, 4);
      // every matrix item of this setting gives a result, so the output stall backs up the input
      if (phase_no == 5) begin
        mats = 6;
        hold_len = HOLD_CYCLES;
      end
      total = mats * m * n;
      if (m * n > 1 && $urandom_range(5) == 0) total += $urandom_range(1, m * n - 1);

      for (k = 0; k < total; k++) begin
        if (phase_no == 6 && k == total / 2) wait_results_done();
        if ($urandom_range(99) < 8)
          offer_request(OP_LOAD, IDX_W'($urandom_range(0, MAX_DIM - 1)), pick_value(),
                        1'b0, 1'b0, NO_RESULT);
        offer_request(OP_MATRIX, IDX_W'($urandom), pick_value(), 1'b0, 1'b0, NO_RESULT);
      end
      phase_no++;
    end

    steady = 1'b0;
    s_axis_tvalid <= 1'b0;
    for (wait_cnt = 0; pending_sums.size() != 0 && wait_cnt < DRAIN_LIMIT; wait_cnt++)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_sums.size() != 0) begin
      $error("%0d expected results never arrived", pending_sums.size());
      fail_count++;
    end

    $display("covered %0d requests (%0d matrix elements) over %0d register writes",
             req_count, elem_count, setting_count);
    $display("checked %0d results, both modes, largest sizes and a long output stall",
             checked_count);
    if (fail_count == 0) begin
      $display("matrix_vector_multiply test passed");
    end else begin
      $display("matrix_vector_multiply test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/mvm_pkg.sv
sv/mvm_accum.sv
sv/matrix_vector_multiply.sv
sv/mvm_checker.sv
test/testbench.sv
